>>> src/triangle_min_inner_angle_top_assert.svh
// Assertion macros used by the checker file of the triangle angle block.
`ifndef TRIANGLE_MIN_INNER_ANGLE_TOP_ASSERT_SVH
`define TRIANGLE_MIN_INNER_ANGLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the block clock and disabled in reset.
`define TMIA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tmia assertion failed");

// Implication whose consequent lands a fixed number of cycles later.
`define TMIA_ASSERT_AFTER(label, ante, cycles, cons) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##cycles (cons)) else $error("tmia latency assertion failed");

`endif

>>> src/tmia_pkg.sv
// Shared types, widths and constants of the triangle minimum angle block.
package tmia_pkg;

   localparam int SIDE_BITS       = 16;
   localparam int ANGLE_BITS      = 17;
   localparam int LENGTH_BITS_DEF = 16;
   localparam int ANGLE_FRAC_DEF  = 16;
   localparam int FACTOR_BITS     = 18;
   localparam int PROD_BITS       = 2 * FACTOR_BITS;
   localparam int MSB_BITS        = 6;
   localparam int NORM_BITS       = 62;
   localparam int NORM_TOP        = 60;
   localparam int SHIFT_BITS      = 5;
   localparam int ROOT_BITS       = NORM_BITS / 2;
   localparam int CORDIC_STEPS    = 30;
   localparam int VEC_BITS        = 34;
   localparam int ACC_BITS        = 32;
   localparam int FRONT_STAGES    = 5;
   localparam int LATENCY         = FRONT_STAGES + ROOT_BITS + CORDIC_STEPS + 1;
   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = '1;

   typedef struct packed {
      logic [SIDE_BITS-1:0] side_a;
      logic [SIDE_BITS-1:0] side_b;
      logic [SIDE_BITS-1:0] side_c;
   } tmia_req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] min_angle;
      logic                  invalid;
   } tmia_rsp_type;

   // Flags that ride along the pipeline with each item.
   typedef struct packed {
      logic invalid;
      logic zero;
   } tmia_tag_type;

   // round(atan(2^-i) * 2^30)
   function automatic logic [ACC_BITS-1:0] atan_q30(input int step);
      logic [ACC_BITS-1:0] t;
      case (step)
         0:  t = 32'd843314857;
         1:  t = 32'd497837830;
         2:  t = 32'd263043837;
         3:  t = 32'd133525159;
         4:  t = 32'd67021687;
         5:  t = 32'd33543516;
         6:  t = 32'd16775851;
         7:  t = 32'd8388437;
         8:  t = 32'd4194283;
         9:  t = 32'd2097149;
         default: t = ACC_BITS'(32'd1 << (30 - step));
      endcase
      return t;
   endfunction

endpackage

>>> src/tmia_sqrt.sv
// Pipelined integer square root, one root bit per stage, two lanes side by side.
module tmia_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  tmia_pkg::tmia_tag_type         in_tag,
   input  logic [tmia_pkg::NORM_BITS-1:0] in_rad_x,
   input  logic [tmia_pkg::NORM_BITS-1:0] in_rad_y,
   output logic                           out_valid,
   output tmia_pkg::tmia_tag_type         out_tag,
   output logic [tmia_pkg::ROOT_BITS-1:0] out_root_x,
   output logic [tmia_pkg::ROOT_BITS-1:0] out_root_y
);
   import tmia_pkg::*;

   localparam int REM_BITS = ROOT_BITS + 3;

   typedef struct packed {
      logic [NORM_BITS-1:0] rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } lane_type;

   // Bring down the next two radicand bits and try to set one more root bit.
   function automatic lane_type sqrt_step(input lane_type cur);
      lane_type            nxt;
      logic [REM_BITS-1:0] cand;
      logic [REM_BITS-1:0] trial;
      cand    = {cur.rem[REM_BITS-3:0], cur.rad[NORM_BITS-1 -: 2]};
      trial   = REM_BITS'({cur.root, 2'b01});
      nxt.rad = cur.rad << 2;
      if (cand >= trial) begin
         nxt.rem  = cand - trial;
         nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         nxt.rem  = cand;
         nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic         vld_ff [ROOT_BITS];
   tmia_tag_type tag_ff [ROOT_BITS];
   lane_type     x_ff   [ROOT_BITS];
   lane_type     y_ff   [ROOT_BITS];

   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
      logic         vld_prev;
      tmia_tag_type tag_prev;
      lane_type     x_prev;
      lane_type     y_prev;

      if (g == 0) begin : g_first
         assign vld_prev = in_valid;
         assign tag_prev = in_tag;
         assign x_prev   = '{rad: in_rad_x, rem: '0, root: '0};
         assign y_prev   = '{rad: in_rad_y, rem: '0, root: '0};
      end else begin : g_next
         assign vld_prev = vld_ff[g-1];
         assign tag_prev = tag_ff[g-1];
         assign x_prev   = x_ff[g-1];
         assign y_prev   = y_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_prev;
         end
         tag_ff[g] <= tag_prev;
         x_ff[g]   <= sqrt_step(x_prev);
         y_ff[g]   <= sqrt_step(y_prev);
      end
   end

   assign out_valid  = vld_ff[ROOT_BITS-1];
   assign out_tag    = tag_ff[ROOT_BITS-1];
   assign out_root_x = x_ff[ROOT_BITS-1].root;
   assign out_root_y = y_ff[ROOT_BITS-1].root;

endmodule

>>> src/tmia_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage, accumulating the angle.
module tmia_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  tmia_pkg::tmia_tag_type         in_tag,
   input  logic [tmia_pkg::ROOT_BITS-1:0] in_x,
   input  logic [tmia_pkg::ROOT_BITS-1:0] in_y,
   output logic                           out_valid,
   output tmia_pkg::tmia_tag_type         out_tag,
   output logic signed [tmia_pkg::ACC_BITS-1:0] out_z
);
   import tmia_pkg::*;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] x;
      logic signed [VEC_BITS-1:0] y;
      logic signed [ACC_BITS-1:0] z;
   } rot_type;

   function automatic rot_type cordic_step(input rot_type cur, input int step);
      rot_type                    nxt;
      logic signed [VEC_BITS-1:0] dx;
      logic signed [VEC_BITS-1:0] dy;
      dx = cur.y >>> step;
      dy = cur.x >>> step;
      if (cur.y > 0) begin
         nxt.x = cur.x + dx;
         nxt.y = cur.y - dy;
         nxt.z = cur.z + $signed(atan_q30(step));
      end else begin
         nxt.x = cur.x - dx;
         nxt.y = cur.y + dy;
         nxt.z = cur.z - $signed(atan_q30(step));
      end
      return nxt;
   endfunction

   logic         vld_ff [CORDIC_STEPS];
   tmia_tag_type tag_ff [CORDIC_STEPS];
   rot_type      rot_ff [CORDIC_STEPS];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
      logic         vld_prev;
      tmia_tag_type tag_prev;
      rot_type      rot_prev;

      if (g == 0) begin : g_first
         assign vld_prev = in_valid;
         assign tag_prev = in_tag;
         assign rot_prev = '{x: $signed(VEC_BITS'(in_x)), y: $signed(VEC_BITS'(in_y)),
                             z: '0};
      end else begin : g_next
         assign vld_prev = vld_ff[g-1];
         assign tag_prev = tag_ff[g-1];
         assign rot_prev = rot_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_prev;
         end
         tag_ff[g] <= tag_prev;
         rot_ff[g] <= cordic_step(rot_prev, g);
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign out_tag   = tag_ff[CORDIC_STEPS-1];
   assign out_z     = rot_ff[CORDIC_STEPS-1].z;

endmodule

>>> src/triangle_min_inner_angle_top.sv
// Top level of the triangle minimum inner angle pipeline.
// Each transfer on the request side carries three side lengths; exactly one result
// follows on the response strobe, in request order. The block takes a new triangle
// in every cycle and busy stays low, since the receiver cannot stall and nothing is
// held back. The pipeline is made of five front stages (sort, factors, multiply,
// leading-bit search, normalize), the 31-stage square root that produces one root
// bit per stage, the 30-stage CORDIC and one rounding stage.
// A zero side or lengths that form no triangle give invalid high and angle zero.
module triangle_min_inner_angle_top #(
   parameter int LENGTH_BITS     = tmia_pkg::LENGTH_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = tmia_pkg::ANGLE_FRAC_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tmia_pkg::tmia_req_type req_data,
   output logic                   rsp_strobe,
   output tmia_pkg::tmia_rsp_type rsp_data
);
   import tmia_pkg::*;

   localparam int MASK_BITS = (LENGTH_BITS < SIDE_BITS) ? LENGTH_BITS : SIDE_BITS;
   localparam int RED_SHIFT = (LENGTH_BITS > SIDE_BITS) ? LENGTH_BITS - SIDE_BITS : 0;
   localparam logic [SIDE_BITS-1:0] SIDE_MASK =
      SIDE_BITS'((64'd1 << MASK_BITS) - 64'd1);
   localparam int RND_SHIFT = 29 - ANGLE_FRAC_BITS;
   localparam int DROP      = 30 - ANGLE_FRAC_BITS;

   assign busy = 1'b0;

   // Sort: shortest side and the two others.
   logic                 a_vld_ff;
   logic [SIDE_BITS-1:0] a_s_ff, a_l1_ff, a_l2_ff;
   logic [SIDE_BITS-1:0] a_s_in, a_l1_in, a_l2_in;
   logic [SIDE_BITS-1:0] sx, sy, sz;

   always_comb begin
      sx      = req_data.side_a & SIDE_MASK;
      sy      = req_data.side_b & SIDE_MASK;
      sz      = req_data.side_c & SIDE_MASK;
      a_s_in  = sx;
      a_l1_in = sy;
      a_l2_in = sz;
      if (sy < a_s_in) begin
         a_s_in  = sy;
         a_l1_in = sx;
         a_l2_in = sz;
      end
      if (sz < a_s_in) begin
         a_s_in  = sz;
         a_l1_in = sx;
         a_l2_in = sy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
      a_s_ff  <= a_s_in;
      a_l1_ff <= a_l1_in;
      a_l2_ff <= a_l2_in;
   end

   // Factors of U = (s-d)(s+d) and V = (p+q-s)(p+q+s).
   logic                   b_vld_ff;
   tmia_tag_type           b_tag_ff, b_tag_in;
   logic [FACTOR_BITS-1:0] b_f1_ff, b_f2_ff, b_g1_ff, b_g2_ff;
   logic [FACTOR_BITS-1:0] b_f1_in, b_f2_in, b_g1_in, b_g2_in;
   logic [SIDE_BITS-1:0]   diff;
   logic [FACTOR_BITS-1:0] s_ext, d_ext, sum_ext;

   always_comb begin
      diff     = (a_l1_ff > a_l2_ff) ? a_l1_ff - a_l2_ff : a_l2_ff - a_l1_ff;
      s_ext    = FACTOR_BITS'(a_s_ff);
      d_ext    = FACTOR_BITS'(diff);
      sum_ext  = FACTOR_BITS'(a_l1_ff) + FACTOR_BITS'(a_l2_ff);
      b_f1_in  = (s_ext - d_ext) >> RED_SHIFT;
      b_f2_in  = (s_ext + d_ext) >> RED_SHIFT;
      b_g1_in  = (sum_ext - s_ext) >> RED_SHIFT;
      b_g2_in  = (sum_ext + s_ext) >> RED_SHIFT;
      b_tag_in.invalid = (a_s_ff == '0) || (diff > a_s_ff);
      b_tag_in.zero    = b_tag_in.invalid || (b_f1_in == '0) || (b_f2_in == '0) ||
                         (b_g1_in == '0) || (b_g2_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_tag_ff <= b_tag_in;
      b_f1_ff  <= b_f1_in;
      b_f2_ff  <= b_f2_in;
      b_g1_ff  <= b_g1_in;
      b_g2_ff  <= b_g2_in;
   end

   // Products.
   logic                 c_vld_ff;
   tmia_tag_type         c_tag_ff;
   logic [PROD_BITS-1:0] c_u_ff, c_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_tag_ff <= b_tag_ff;
      c_u_ff   <= b_f1_ff * b_f2_ff;
      c_v_ff   <= b_g1_ff * b_g2_ff;
   end

   // Leading-bit search on V gives the count of two-bit shifts that bring the leading bit of V to bit 60 or 61.
   logic                  d_vld_ff;
   tmia_tag_type          d_tag_ff;
   logic [PROD_BITS-1:0]  d_u_ff, d_v_ff;
   logic [SHIFT_BITS-1:0] d_k_ff, d_k_in;
   logic [MSB_BITS-1:0]   msb;

   always_comb begin
      msb = '0;
      for (int j = 0; j < PROD_BITS; j++) begin
         if (c_v_ff[j]) begin
            msb = MSB_BITS'(j);
         end
      end
      d_k_in = SHIFT_BITS'((MSB_BITS'(NORM_TOP + 1) - msb) >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
      d_tag_ff <= c_tag_ff;
      d_u_ff   <= c_u_ff;
      d_v_ff   <= c_v_ff;
      d_k_ff   <= d_k_in;
   end

   // Normalize both terms by the same even shift.
   logic                 e_vld_ff;
   tmia_tag_type         e_tag_ff;
   logic [NORM_BITS-1:0] e_u_ff, e_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
      e_tag_ff <= d_tag_ff;
      e_u_ff   <= NORM_BITS'(d_u_ff) << {d_k_ff, 1'b0};
      e_v_ff   <= NORM_BITS'(d_v_ff) << {d_k_ff, 1'b0};
   end

   logic                 r_vld;
   tmia_tag_type         r_tag;
   logic [ROOT_BITS-1:0] r_x, r_y;

   tmia_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (e_vld_ff),
      .in_tag     (e_tag_ff),
      .in_rad_x   (e_v_ff),
      .in_rad_y   (e_u_ff),
      .out_valid  (r_vld),
      .out_tag    (r_tag),
      .out_root_x (r_x),
      .out_root_y (r_y)
   );

   logic                       k_vld;
   tmia_tag_type               k_tag;
   logic signed [ACC_BITS-1:0] k_z;

   tmia_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_vld),
      .in_tag    (r_tag),
      .in_x      (r_x),
      .in_y      (r_y),
      .out_valid (k_vld),
      .out_tag   (k_tag),
      .out_z     (k_z)
   );

   // Double the half angle, round to the output scale and saturate.
   logic                  o_vld_ff;
   tmia_rsp_type          o_rsp_ff, o_rsp_in;
   logic [ACC_BITS-2:0]   z_clamp;
   logic [ACC_BITS:0]     ang_sum, ang_full;

   always_comb begin
      z_clamp  = k_z[ACC_BITS-1] ? '0 : k_z[ACC_BITS-2:0];
      ang_sum  = {1'b0, z_clamp, 1'b0} + ((ACC_BITS+1)'(1) << RND_SHIFT);
      ang_full = ang_sum >> DROP;
      o_rsp_in.invalid = k_tag.invalid;
      if (k_tag.zero) begin
         o_rsp_in.min_angle = '0;
      end else if (ang_full > (ACC_BITS+1)'(ANGLE_MAX)) begin
         o_rsp_in.min_angle = ANGLE_MAX;
      end else begin
         o_rsp_in.min_angle = ang_full[ANGLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= k_vld;
      end
      o_rsp_ff <= o_rsp_in;
   end

   assign rsp_strobe = o_vld_ff;
   assign rsp_data   = o_rsp_ff;

endmodule

>>> src/tmia_checker.sv
// Port-level checker of the triangle minimum angle block and its bind.
`include "triangle_min_inner_angle_top_assert.svh"

module tmia_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input tmia_pkg::tmia_rsp_type rsp_data
);
   import tmia_pkg::*;

   // Every transfer returns its result after the fixed pipeline latency.
   `TMIA_ASSERT_AFTER(a_latency, start && !busy, LATENCY, rsp_strobe)
   // No result appears without a transfer that long ago.
   `TMIA_ASSERT_NOW(a_no_orphan, rsp_strobe, $past(start && !busy, LATENCY))
   // A rejected triangle always reports a zero angle.
   `TMIA_ASSERT_NOW(a_invalid_zero, rsp_strobe && rsp_data.invalid, rsp_data.min_angle == '0)
   // Nothing in the pipeline can hold off the request side.
   `TMIA_ASSERT_NOW(a_never_busy, 1'b1, !busy)

endmodule

bind triangle_min_inner_angle_top tmia_checker u_tmia_checker (.*);
